// ----- hdl/bqr_pkg.sv -----
// ----------------------------------------------------------------------------
// bqr_pkg
// Shared types and fixed field widths of the bounded queue with removal.
// ----------------------------------------------------------------------------
package bqr_pkg;

    localparam int CMD_W    = 3;
    localparam int VALUE_W  = 32;
    localparam int STATUS_W = 2;
    localparam int DATA_W   = 32;
    localparam int OCC_W    = 5;
    localparam int CAP_W    = 5;

    localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

    typedef enum logic [CMD_W-1:0] {
        CMD_PUT    = 3'd0,
        CMD_GET    = 3'd1,
        CMD_POP    = 3'd2,
        CMD_REMOVE = 3'd3,
        CMD_COUNT  = 3'd4
    } cmd_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 2'd0,
        ST_FULL      = 2'd1,
        ST_EMPTY     = 2'd2,
        ST_NOT_FOUND = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_RDATA,
        S_SCAN,
        S_SHIFT,
        S_RESP
    } state_t;

    typedef struct packed {
        status_t             status;
        logic [DATA_W-1:0]   data;
        logic [OCC_W-1:0]    occupancy;
    } res_t;

endpackage

// ----- hdl/bqr_ram.sv -----
// ----------------------------------------------------------------------------
// bqr_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module bqr_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ----- hdl/bqr_seq.sv -----
// ----------------------------------------------------------------------------
// bqr_seq
// Command sequencer: decodes one command, drives the entry RAM, scans and
// shifts for remove, and presents one result to the output register.
// ----------------------------------------------------------------------------
module bqr_seq #(
    parameter int DEPTH     = 16,
    parameter int WORD_BITS = 32
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [bqr_pkg::CMD_W-1:0]     s_command,
    input  logic [bqr_pkg::VALUE_W-1:0]   s_value,
    input  logic                          cfg_we,
    input  logic [bqr_pkg::CAP_W-1:0]     cfg_data,
    output logic                          mem_we,
    output logic [$clog2(DEPTH)-1:0]      mem_waddr,
    output logic [WORD_BITS-1:0]          mem_wdata,
    output logic [$clog2(DEPTH)-1:0]      mem_raddr,
    input  logic [WORD_BITS-1:0]          mem_rdata,
    output logic                          res_valid,
    input  logic                          res_ready,
    output bqr_pkg::res_t                 res
);

    import bqr_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int LW = (CW > CAP_W) ? CW : CAP_W;

    state_t               state_reg, state_next;
    cmd_t                 cmd_reg, cmd_next;
    logic [WORD_BITS-1:0] word_reg, word_next;
    logic [AW-1:0]        head_reg, head_next;
    logic [CW-1:0]        count_reg, count_next;
    logic [CW-1:0]        idx_reg, idx_next;
    status_t              status_reg, status_next;
    logic [DATA_W-1:0]    data_reg, data_next;
    logic [CAP_W-1:0]     cap_reg, cap_next;

    logic          accept;
    logic          full;
    logic          empty;
    logic          hit;
    logic [CW-1:0] idx_p1;
    logic [CW-1:0] idx_p2;

    function automatic logic [AW-1:0] slot(input logic [AW-1:0] head,
                                           input logic [CW-1:0] off);
        logic [CW:0] sum;
        sum = (CW+1)'(head) + (CW+1)'(off);
        if (sum >= (CW+1)'(DEPTH)) begin
            sum = sum - (CW+1)'(DEPTH);
        end
        return sum[AW-1:0];
    endfunction

    assign s_ready = (state_reg == S_IDLE) || ((state_reg == S_RESP) && res_ready);
    assign accept  = s_valid && s_ready;
    assign full    = (LW'(count_reg) >= LW'(cap_reg)) || (count_reg == CW'(DEPTH));
    assign empty   = (count_reg == '0);
    assign hit     = (mem_rdata == word_reg);
    assign idx_p1  = idx_reg + CW'(1);
    assign idx_p2  = idx_reg + CW'(2);

    assign res_valid     = (state_reg == S_RESP);
    assign res.status    = status_reg;
    assign res.data      = data_reg;
    assign res.occupancy = OCC_W'(count_reg);

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    state_next = S_DECODE;
                end
            end
            S_DECODE: begin
                case (cmd_reg)
                    CMD_GET, CMD_POP: state_next = empty ? S_RESP : S_RDATA;
                    CMD_REMOVE:       state_next = empty ? S_RESP : S_SCAN;
                    default:          state_next = S_RESP;
                endcase
            end
            S_RDATA: state_next = S_RESP;
            S_SCAN: begin
                if (idx_p1 < count_reg) begin
                    state_next = hit ? S_SHIFT : S_SCAN;
                end else begin
                    state_next = S_RESP;
                end
            end
            S_SHIFT: begin
                if (idx_p2 >= count_reg) begin
                    state_next = S_RESP;
                end
            end
            S_RESP: begin
                if (res_ready) begin
                    state_next = accept ? S_DECODE : S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_comb begin
        cmd_next    = cmd_reg;
        word_next   = word_reg;
        head_next   = head_reg;
        count_next  = count_reg;
        idx_next    = idx_reg;
        status_next = status_reg;
        data_next   = data_reg;
        cap_next    = cfg_we ? cfg_data : cap_reg;
        mem_we      = 1'b0;
        mem_waddr   = slot(head_reg, count_reg);
        mem_wdata   = word_reg;
        mem_raddr   = slot(head_reg, '0);

        if (accept) begin
            cmd_next  = cmd_t'(s_command);
            word_next = WORD_BITS'(s_value);
        end

        case (state_reg)
            S_DECODE: begin
                status_next = ST_OK;
                data_next   = '0;
                idx_next    = '0;
                case (cmd_reg)
                    CMD_PUT: begin
                        if (full) begin
                            status_next = ST_FULL;
                        end else begin
                            mem_we     = 1'b1;
                            count_next = count_reg + CW'(1);
                        end
                    end
                    CMD_GET: begin
                        if (empty) begin
                            status_next = ST_EMPTY;
                        end
                    end
                    CMD_POP: begin
                        if (empty) begin
                            status_next = ST_EMPTY;
                        end
                        mem_raddr = slot(head_reg, count_reg - CW'(1));
                    end
                    CMD_REMOVE: begin
                        if (empty) begin
                            status_next = ST_NOT_FOUND;
                        end
                    end
                    default: ;
                endcase
            end
            S_RDATA: begin
                data_next  = DATA_W'(mem_rdata);
                count_next = count_reg - CW'(1);
                if (cmd_reg == CMD_GET) begin
                    head_next = slot(head_reg, CW'(1));
                end
            end
            S_SCAN: begin
                mem_raddr = slot(head_reg, idx_p1);
                if (hit) begin
                    if (idx_p1 >= count_reg) begin
                        count_next = count_reg - CW'(1);
                    end
                end else if (idx_p1 < count_reg) begin
                    idx_next = idx_p1;
                end else begin
                    status_next = ST_NOT_FOUND;
                end
            end
            S_SHIFT: begin
                // move entry idx+1 down into idx, fetch idx+2
                mem_we    = 1'b1;
                mem_waddr = slot(head_reg, idx_reg);
                mem_wdata = mem_rdata;
                mem_raddr = slot(head_reg, idx_p2);
                if (idx_p2 < count_reg) begin
                    idx_next = idx_p1;
                end else begin
                    count_next = count_reg - CW'(1);
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            head_reg  <= '0;
            count_reg <= '0;
            cap_reg   <= CAP_RESET;
        end else begin
            state_reg <= state_next;
            head_reg  <= head_next;
            count_reg <= count_next;
            cap_reg   <= cap_next;
        end
    end

    always_ff @(posedge aclk) begin
        cmd_reg    <= cmd_next;
        word_reg   <= word_next;
        idx_reg    <= idx_next;
        status_reg <= status_next;
        data_reg   <= data_next;
    end

endmodule

// ----- hdl/bounded_queue_with_removal_unit.sv -----
// ----------------------------------------------------------------------------
// bounded_queue_with_removal_unit
// Each command passes decode and then the result state; on a nonempty queue,
// get and pop also pass the RAM read state and remove scans the entries (one
// RAM read per entry), shifting on a hit. A new command is taken in idle or as
// the result is taken; remove holds the input until its scan and shift are done.
// Synchronous reset empties the queue and sets the capacity limit to 16;
// the entry RAM is not cleared.
// ----------------------------------------------------------------------------
module bounded_queue_with_removal_unit #(
    parameter int DEPTH     = 16,
    parameter int WORD_BITS = 32
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [bqr_pkg::CMD_W-1:0]     s_command,
    input  logic [bqr_pkg::VALUE_W-1:0]   s_value,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [bqr_pkg::STATUS_W-1:0]  m_status,
    output logic [bqr_pkg::DATA_W-1:0]    m_data_out,
    output logic [bqr_pkg::OCC_W-1:0]     m_occupancy,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [bqr_pkg::CAP_W-1:0]     cfg_data
);

    import bqr_pkg::*;

    localparam int AW = $clog2(DEPTH);

    logic                 mem_we;
    logic [AW-1:0]        mem_waddr;
    logic [WORD_BITS-1:0] mem_wdata;
    logic [AW-1:0]        mem_raddr;
    logic [WORD_BITS-1:0] mem_rdata;
    logic                 res_valid;
    logic                 res_ready;
    res_t                 res;

    logic                 m_valid_reg, m_valid_next;
    logic [STATUS_W-1:0]  m_status_reg, m_status_next;
    logic [DATA_W-1:0]    m_data_reg, m_data_next;
    logic [OCC_W-1:0]     m_occ_reg, m_occ_next;

    assign cfg_ready = 1'b1;
    assign res_ready = !m_valid_reg || m_ready;

    bqr_seq #(
        .DEPTH     (DEPTH),
        .WORD_BITS (WORD_BITS)
    ) u_seq (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_command (s_command),
        .s_value   (s_value),
        .cfg_we    (cfg_valid && cfg_ready),
        .cfg_data  (cfg_data),
        .mem_we    (mem_we),
        .mem_waddr (mem_waddr),
        .mem_wdata (mem_wdata),
        .mem_raddr (mem_raddr),
        .mem_rdata (mem_rdata),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res)
    );

    bqr_ram #(
        .WIDTH (WORD_BITS),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk   (aclk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    always_comb begin
        m_valid_next  = m_valid_reg;
        m_status_next = m_status_reg;
        m_data_next   = m_data_reg;
        m_occ_next    = m_occ_reg;
        if (res_ready) begin
            m_valid_next = res_valid;
            if (res_valid) begin
                m_status_next = res.status;
                m_data_next   = res.data;
                m_occ_next    = res.occupancy;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_status_reg <= m_status_next;
        m_data_reg   <= m_data_next;
        m_occ_reg    <= m_occ_next;
    end

    assign m_valid     = m_valid_reg;
    assign m_status    = m_status_reg;
    assign m_data_out  = m_data_reg;
    assign m_occupancy = m_occ_reg;

endmodule

// ----- hdl/bqr_checker.sv -----
// ----------------------------------------------------------------------------
// bqr_checker
// Port-level checks on the result channel, bound to the top level.
// ----------------------------------------------------------------------------
module bqr_checker #(
    parameter int DEPTH = 16
) (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          m_valid,
    input logic                          m_ready,
    input logic [bqr_pkg::STATUS_W-1:0]  m_status,
    input logic [bqr_pkg::DATA_W-1:0]    m_data_out,
    input logic [bqr_pkg::OCC_W-1:0]     m_occupancy
);

    import bqr_pkg::*;

    localparam int OCC_MAX = (DEPTH < (1 << OCC_W)) ? DEPTH : ((1 << OCC_W) - 1);

    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_status) && $stable(m_data_out)
            && $stable(m_occupancy))
        else $error("result beat changed while stalled");

    a_data_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_data_out != '0) |-> m_status == ST_OK)
        else $error("nonzero data on a failed command");

    a_empty_occ: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_status == ST_EMPTY) |-> m_occupancy == '0)
        else $error("empty status with entries held");

    a_occ_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> int'(m_occupancy) <= OCC_MAX)
        else $error("occupancy beyond depth");

endmodule

bind bounded_queue_with_removal_unit bqr_checker #(.DEPTH(DEPTH)) u_bqr_checker (.*);
